FILE: rtl/core/hsdd_pkg.sv
package hsdd_pkg;

   localparam int unsigned DEF_BUCKETS = 512;
   localparam int unsigned DEF_ENTRIES = 1024;
   localparam int unsigned CFG_W = 10;
   localparam logic [CFG_W-1:0] CFG_RESET = 10'd512;
   localparam int unsigned VAL_W = 32;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_BKT,
      ST_BKT_WAIT,
      ST_NODE,
      ST_NODE_WAIT,
      ST_APPEND,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic clear_step;
      logic load_item;
      logic div_step;
      logic bkt_read;
      logic node_read;
      logic node_advance;
      logic append;
      logic mark_dup;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic div_done;
      logic skip;
      logic last;
      logic bkt_used;
      logic node_match;
      logic node_end;
   } status_type;

endpackage

FILE: rtl/core/hash_set_duplicate_detector.sv
// Channel | Direction | Signals
// req     | in        | req_valid, req_ready, req_value, req_last_item
// rsp     | out       | rsp_valid, rsp_ready, rsp_duplicate_found, rsp_pool_overflow
// csr     | in        | csr_write, csr_wdata
// A transaction into an empty bucket is accepted, runs the 32-step restoring remainder,
// reads the bucket (ST_BKT, ST_BKT_WAIT) and appends a node (ST_APPEND).
// Each chain node walked adds a node read, and a match ends the walk with no append.
// Once a duplicate is seen, the rest of the array is accepted and skipped unhashed.
// After reset and after each result the bucket flags are cleared one at a time.
// The input stalls during the clear, while an item is at work or a result waits.
module hash_set_duplicate_detector #(
   parameter int unsigned BUCKETS = hsdd_pkg::DEF_BUCKETS,
   parameter int unsigned ENTRIES = hsdd_pkg::DEF_ENTRIES
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [hsdd_pkg::CFG_W-1:0] csr_wdata,
   input  logic req_valid,
   output logic req_ready,
   input  logic signed [hsdd_pkg::VAL_W-1:0] req_value,
   input  logic req_last_item,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic rsp_duplicate_found,
   output logic rsp_pool_overflow
);
   import hsdd_pkg::*;

   cmd_type cmd;
   status_type sts;

   hsdd_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .sts, .cmd
   );

   hsdd_dp #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES)) u_dp (
      .clock, .reset, .csr_write, .csr_wdata, .req_value, .req_last_item,
      .rsp_duplicate_found, .rsp_pool_overflow, .cmd, .sts
   );
endmodule

FILE: rtl/core/hsdd_ctrl.sv
module hsdd_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   input  hsdd_pkg::status_type sts,
   output hsdd_pkg::cmd_type cmd
);
   import hsdd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (sts.skip) state_in = sts.last ? ST_RESULT : ST_IDLE;
            else if (sts.div_done) state_in = ST_BKT;
         end
         ST_BKT: state_in = ST_BKT_WAIT;
         ST_BKT_WAIT: state_in = sts.bkt_used ? ST_NODE : ST_APPEND;
         ST_NODE: state_in = ST_NODE_WAIT;
         ST_NODE_WAIT: begin
            if (sts.node_match) state_in = sts.last ? ST_RESULT : ST_IDLE;
            else if (sts.node_end) state_in = ST_APPEND;
            else state_in = ST_NODE;
         end
         ST_APPEND: state_in = sts.last ? ST_RESULT : ST_IDLE;
         ST_RESULT: begin
            if (rsp_ready) state_in = ST_CLEAR;
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_CLEAR: cmd.clear_step = 1'b1;
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load_item = req_valid;
         end
         ST_DIV: cmd.div_step = 1'b1;
         ST_BKT: cmd.bkt_read = 1'b1;
         ST_NODE: cmd.node_read = 1'b1;
         ST_NODE_WAIT: begin
            cmd.mark_dup = sts.node_match;
            cmd.node_advance = !sts.node_match;
         end
         ST_APPEND: cmd.append = 1'b1;
         ST_RESULT: begin
            rsp_valid = 1'b1;
            cmd.finish = rsp_ready;
         end
         default: cmd = '0;
      endcase
   end

`ifndef ASSERT_OFF
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid) else $error("ready while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
   a_clear_after: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> state_ff == ST_CLEAR) else $error("no clear");
`endif
endmodule

FILE: rtl/core/hsdd_dp.sv
module hsdd_dp #(
   parameter int unsigned BUCKETS = hsdd_pkg::DEF_BUCKETS,
   parameter int unsigned ENTRIES = hsdd_pkg::DEF_ENTRIES
) (
   input  logic clock,
   input  logic reset,
   input  logic csr_write,
   input  logic [hsdd_pkg::CFG_W-1:0] csr_wdata,
   input  logic signed [hsdd_pkg::VAL_W-1:0] req_value,
   input  logic req_last_item,
   output logic rsp_duplicate_found,
   output logic rsp_pool_overflow,
   input  hsdd_pkg::cmd_type cmd,
   output hsdd_pkg::status_type sts
);
   import hsdd_pkg::*;

   localparam int unsigned BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int unsigned NW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int unsigned CW = $clog2(ENTRIES + 1);
   localparam int unsigned DW = $clog2(BUCKETS + 1);
   localparam int unsigned QW = (DW > CFG_W) ? DW : CFG_W;
   localparam int unsigned SW = (VAL_W > 1) ? $clog2(VAL_W) : 1;

   logic [CFG_W-1:0] cfg_ff;
   logic [VAL_W-1:0] val_ff;
   logic last_ff, dup_ff, ovf_ff;
   logic [CW-1:0] used_cnt_ff;
   logic [VAL_W-1:0] mag_ff;
   logic [DW-1:0] rem_ff, div_ff;
   logic [SW-1:0] bit_ff;
   logic div_done_ff;
   logic [BW-1:0] bkt_ff, clr_ff;
   logic [NW-1:0] node_ff, tail_ff;
   logic have_tail_ff;
   logic [NW:0] guard_ff;

   logic [NW-1:0] head_mem [BUCKETS];
   logic          used_mem [BUCKETS];
   logic [VAL_W-1:0] nval_mem [ENTRIES];
   logic [NW-1:0] nlink_mem [ENTRIES];
   logic          nend_mem [ENTRIES];

   logic [NW-1:0] head_rd;
   logic used_rd;
   logic [VAL_W-1:0] nval_rd;
   logic [NW-1:0] nlink_rd;
   logic nend_rd;
   logic [DW:0] trial;
   logic [QW-1:0] cfg_ext;
   logic [DW-1:0] div_sel;
   logic [BW-1:0] bkt_addr;

   assign cfg_ext = QW'(cfg_ff);
   always_comb begin
      if (cfg_ff == '0) div_sel = DW'(1);
      else if (cfg_ext > QW'(BUCKETS)) div_sel = DW'(BUCKETS);
      else div_sel = DW'(cfg_ext);
   end

   assign trial = {rem_ff, mag_ff[bit_ff]} - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) cfg_ff <= CFG_RESET;
      else if (csr_write) cfg_ff <= csr_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         dup_ff <= 1'b0;
         ovf_ff <= 1'b0;
         used_cnt_ff <= '0;
         clr_ff <= '0;
      end else begin
         if (cmd.clear_step) clr_ff <= clr_ff + BW'(1);
         if (cmd.mark_dup) dup_ff <= 1'b1;
         if (cmd.append) begin
            if (used_cnt_ff >= CW'(ENTRIES)) ovf_ff <= 1'b1;
            else used_cnt_ff <= used_cnt_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         val_ff <= req_value;
         last_ff <= req_last_item;
         mag_ff <= req_value[VAL_W-1] ? (VAL_W'(0) - req_value) : req_value;
         rem_ff <= '0;
         div_ff <= div_sel;
         bit_ff <= SW'(VAL_W - 1);
         div_done_ff <= 1'b0;
         have_tail_ff <= 1'b0;
         guard_ff <= '0;
      end
      if (cmd.div_step && !div_done_ff) begin
         if (!trial[DW]) rem_ff <= trial[DW-1:0];
         else rem_ff <= {rem_ff[DW-2:0], mag_ff[bit_ff]};
         if (bit_ff == '0) div_done_ff <= 1'b1;
         else bit_ff <= bit_ff - SW'(1);
      end
      if (cmd.bkt_read) bkt_ff <= BW'(rem_ff);
      if (cmd.node_read && !have_tail_ff && guard_ff == '0) node_ff <= head_rd;
      if (cmd.node_advance) begin
         tail_ff <= node_ff;
         have_tail_ff <= 1'b1;
         if (!sts.node_end) begin
            node_ff <= nlink_rd;
            guard_ff <= guard_ff + (NW+1)'(1);
         end
      end
   end

   assign bkt_addr = cmd.bkt_read ? BW'(rem_ff) : bkt_ff;

   always_ff @(posedge clock) begin
      head_rd <= head_mem[bkt_addr];
      if (cmd.clear_step) used_mem[clr_ff] <= 1'b0;
      else if (cmd.append && used_cnt_ff < CW'(ENTRIES) && !have_tail_ff) begin
         used_mem[bkt_ff] <= 1'b1;
         head_mem[bkt_ff] <= NW'(used_cnt_ff);
      end
      used_rd <= used_mem[bkt_addr];
   end

   logic [NW-1:0] rd_addr;
   assign rd_addr = (!have_tail_ff && guard_ff == '0) ? head_rd : node_ff;

   always_ff @(posedge clock) begin
      nval_rd <= nval_mem[rd_addr];
      nlink_rd <= nlink_mem[rd_addr];
      nend_rd <= nend_mem[rd_addr];
      if (cmd.append && used_cnt_ff < CW'(ENTRIES)) begin
         nval_mem[NW'(used_cnt_ff)] <= val_ff;
         nend_mem[NW'(used_cnt_ff)] <= 1'b1;
         if (have_tail_ff) begin
            nlink_mem[tail_ff] <= NW'(used_cnt_ff);
            nend_mem[tail_ff] <= 1'b0;
         end
      end
   end

   assign sts.clear_done = (clr_ff == BW'(BUCKETS - 1)) && cmd.clear_step;
   assign sts.div_done = div_done_ff;
   assign sts.skip = dup_ff;
   assign sts.last = last_ff;
   assign sts.bkt_used = used_rd;
   assign sts.node_match = (nval_rd == val_ff);
   assign sts.node_end = nend_rd || guard_ff == (NW+1)'(ENTRIES - 1);

   assign rsp_duplicate_found = dup_ff;
   assign rsp_pool_overflow = ovf_ff;

`ifndef ASSERT_OFF
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      used_cnt_ff <= CW'(ENTRIES)) else $error("node count overflow");
   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      $rose(ovf_ff) |-> used_cnt_ff == CW'(ENTRIES)) else $error("early overflow");
   a_rem_lt: assert property (@(posedge clock) disable iff (reset)
      cmd.bkt_read |-> rem_ff < div_ff) else $error("remainder too large");
`endif
endmodule
